// ----- design/cfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants for the conductor Fresnel reflectance pipeline: field
// widths, fixed-point widths of the intermediate terms and step settings of
// the iterative divide and square-root pipelines.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned FieldW = 16;
  localparam logic [FieldW-1:0] OuterIndexRst = 16'd4096;
  localparam logic [FieldW-1:0] OneQ15 = 16'h8000;

  // relative index eta, kappa: Q.16, saturated at 64.0
  localparam int unsigned RelW = 23;
  localparam logic [RelW-1:0] RelMax = 23'h400000;

  localparam int unsigned Sq2W   = 29;  // eta^2, kappa^2
  localparam int unsigned Cos2W  = 17;  // cos^2, sin^2
  localparam int unsigned T0W    = 30;  // signed t0
  localparam int unsigned SumW   = 60;  // t0^2 + 4 eta^2 kappa^2
  localparam int unsigned SW     = 30;  // S
  localparam int unsigned AValW  = 46;  // (S + t0) << 15
  localparam int unsigned AW     = 23;  // a
  localparam int unsigned T1W    = 31;
  localparam int unsigned T2W    = 25;
  localparam int unsigned T3W    = 47;
  localparam int unsigned T4W    = 42;
  localparam int unsigned RsDenW = 32;
  localparam int unsigned RsNumW = 47;
  localparam int unsigned FDenW  = 48;
  localparam int unsigned FNumW  = 63;
  localparam int unsigned RatioW = 16;

  // default number of iteration steps done in one pipeline stage
  localparam int unsigned RelStepsDef   = 2;
  localparam int unsigned RootSStepsDef = 1;
  localparam int unsigned RootAStepsDef = 2;
  localparam int unsigned RatioStepsDef = 1;

endpackage

// ----- design/cfr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_div
// Pipelined restoring divider. Produces QuoW quotient bits, StepsPerStage
// bits per register stage. The dividend must be below den << QuoW.
// ----------------------------------------------------------------------------
module cfr_div #(
  parameter int unsigned NumW          = 32,
  parameter int unsigned DenW          = 16,
  parameter int unsigned QuoW          = 23,
  parameter int unsigned StepsPerStage = 2,
  parameter int unsigned SideW         = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             in_valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             out_valid_o,
  output logic [QuoW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned RemW      = DenW + QuoW;
  localparam int unsigned NumStages = (QuoW + StepsPerStage - 1) / StepsPerStage;

  logic             valid_q [NumStages];
  logic [RemW-1:0]  rem_q   [NumStages];
  logic [DenW-1:0]  den_q   [NumStages];
  logic [QuoW-1:0]  quo_q   [NumStages];
  logic [SideW-1:0] side_q  [NumStages];

  logic [RemW-1:0]  rem_d   [NumStages];
  logic [QuoW-1:0]  quo_d   [NumStages];
  logic [DenW-1:0]  den_d   [NumStages];

  always_comb begin
    int unsigned step;
    int unsigned pos;
    logic [RemW-1:0] trial;
    for (int st = 0; st < NumStages; st++) begin
      if (st == 0) begin
        rem_d[st] = RemW'(num_i);
        quo_d[st] = '0;
        den_d[st] = den_i;
      end else begin
        rem_d[st] = rem_q[st-1];
        quo_d[st] = quo_q[st-1];
        den_d[st] = den_q[st-1];
      end
      for (int j = 0; j < StepsPerStage; j++) begin
        step = st * StepsPerStage + j;
        if (step < QuoW) begin
          pos   = QuoW - 1 - step;
          trial = RemW'(den_d[st]) << pos;
          if (rem_d[st] >= trial) begin
            rem_d[st] = rem_d[st] - trial;
            quo_d[st] = quo_d[st] | (QuoW'(1) << pos);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int st = 0; st < NumStages; st++) valid_q[st] <= 1'b0;
    end else if (adv_i) begin
      for (int st = 0; st < NumStages; st++) begin
        if (st == 0) valid_q[st] <= in_valid_i;
        else         valid_q[st] <= valid_q[st-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int st = 0; st < NumStages; st++) begin
        rem_q[st] <= rem_d[st];
        quo_q[st] <= quo_d[st];
        den_q[st] <= den_d[st];
        if (st == 0) side_q[st] <= side_i;
        else         side_q[st] <= side_q[st-1];
      end
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign quo_o       = quo_q[NumStages-1];
  assign side_o      = side_q[NumStages-1];

endmodule

// ----- design/cfr_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_sqrt
// Pipelined floor square root, digit by digit. RootW result bits,
// StepsPerStage bits per register stage.
// ----------------------------------------------------------------------------
module cfr_sqrt #(
  parameter int unsigned RootW         = 30,
  parameter int unsigned StepsPerStage = 1,
  parameter int unsigned SideW         = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic [2*RootW-1:0] val_i,
  input  logic [SideW-1:0]   side_i,
  output logic               out_valid_o,
  output logic [RootW-1:0]   root_o,
  output logic [SideW-1:0]   side_o
);

  localparam int unsigned ValW      = 2 * RootW;
  localparam int unsigned NumStages = (RootW + StepsPerStage - 1) / StepsPerStage;

  logic             valid_q [NumStages];
  logic [ValW-1:0]  rem_q   [NumStages];
  logic [RootW-1:0] root_q  [NumStages];
  logic [SideW-1:0] side_q  [NumStages];

  logic [ValW-1:0]  rem_d   [NumStages];
  logic [RootW-1:0] root_d  [NumStages];

  always_comb begin
    int unsigned step;
    int unsigned pos;
    logic [ValW-1:0] trial;
    for (int st = 0; st < NumStages; st++) begin
      if (st == 0) begin
        rem_d[st]  = val_i;
        root_d[st] = '0;
      end else begin
        rem_d[st]  = rem_q[st-1];
        root_d[st] = root_q[st-1];
      end
      for (int j = 0; j < StepsPerStage; j++) begin
        step = st * StepsPerStage + j;
        if (step < RootW) begin
          pos = RootW - 1 - step;
          // (r + 2^pos)^2 - r^2, with r holding only bits above pos
          trial = (ValW'(root_d[st]) << (pos + 1)) | (ValW'(1) << (2 * pos));
          if (rem_d[st] >= trial) begin
            rem_d[st]  = rem_d[st] - trial;
            root_d[st] = root_d[st] | (RootW'(1) << pos);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int st = 0; st < NumStages; st++) valid_q[st] <= 1'b0;
    end else if (adv_i) begin
      for (int st = 0; st < NumStages; st++) begin
        if (st == 0) valid_q[st] <= in_valid_i;
        else         valid_q[st] <= valid_q[st-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int st = 0; st < NumStages; st++) begin
        rem_q[st]  <= rem_d[st];
        root_q[st] <= root_d[st];
        if (st == 0) side_q[st] <= side_i;
        else         side_q[st] <= side_q[st-1];
      end
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign root_o      = root_q[NumStages-1];
  assign side_o      = side_q[NumStages-1];

endmodule

// ----- design/conductor_fresnel_reflectance_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conductor_fresnel_reflectance_unit
// Exact unpolarized Fresnel reflectance of a conductor, one spectral channel
// per transaction, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_data_i (outer index, Q4.12)
//  in      | in_valid_i/in_ready_o   | cos_incident_i, inner_n_i, inner_k_i
//  out     | out_valid_o/out_ready_i | reflectance_o (Q1.15)
//
// One transaction enters per cycle while in_ready_o is high. With the default
// step settings the two relative-index dividers have 12 stages, the two
// square-root pipelines 30 and 12 stages and the ratio dividers 16.
// Reset clears all valid bits and loads the outer index with 1.0.
// The pipeline stalls as a whole only when the output register holds an
// untaken result and the stage behind it is full; bubbles keep moving.
// ----------------------------------------------------------------------------
module conductor_fresnel_reflectance_unit #(
  parameter int unsigned RelSteps   = cfr_pkg::RelStepsDef,
  parameter int unsigned RootSSteps = cfr_pkg::RootSStepsDef,
  parameter int unsigned RootASteps = cfr_pkg::RootAStepsDef,
  parameter int unsigned RatioSteps = cfr_pkg::RatioStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] cos_incident_i,
  input  logic [15:0]        inner_n_i,
  input  logic [15:0]        inner_k_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        reflectance_o
);

  localparam int unsigned RelW   = cfr_pkg::RelW;
  localparam int unsigned Sq2W   = cfr_pkg::Sq2W;
  localparam int unsigned Cos2W  = cfr_pkg::Cos2W;
  localparam int unsigned T0W    = cfr_pkg::T0W;
  localparam int unsigned SumW   = cfr_pkg::SumW;
  localparam int unsigned SW     = cfr_pkg::SW;
  localparam int unsigned AValW  = cfr_pkg::AValW;
  localparam int unsigned AW     = cfr_pkg::AW;
  localparam int unsigned T1W    = cfr_pkg::T1W;
  localparam int unsigned T2W    = cfr_pkg::T2W;
  localparam int unsigned T3W    = cfr_pkg::T3W;
  localparam int unsigned T4W    = cfr_pkg::T4W;
  localparam int unsigned RsDenW = cfr_pkg::RsDenW;
  localparam int unsigned RsNumW = cfr_pkg::RsNumW;
  localparam int unsigned FDenW  = cfr_pkg::FDenW;
  localparam int unsigned FNumW  = cfr_pkg::FNumW;
  localparam int unsigned RatioW = cfr_pkg::RatioW;
  localparam int unsigned SideSW = T0W + Cos2W + 16;
  localparam int unsigned SideAW = SW + Cos2W + 16;

  logic adv;
  logic out_load;

  // configuration register
  logic [15:0] outer_index_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_index_q <= cfr_pkg::OuterIndexRst;
    end else if (cfg_valid_i) begin
      outer_index_q <= cfg_data_i;
    end
  end

  // input preparation
  logic [15:0] cos_raw;
  logic [15:0] cos_mag;
  logic [15:0] outer_eff;
  logic        sat_n;
  logic        sat_k;

  always_comb begin
    cos_raw   = cos_incident_i;
    cos_mag   = cos_raw[15] ? (16'h0000 - cos_raw) : cos_raw;
    outer_eff = (outer_index_q == 16'h0000) ? 16'h0001 : outer_index_q;
    // quotient of 2^23 or more: saturate without dividing
    sat_n     = {7'b0, inner_n_i} >= {outer_eff, 7'b0};
    sat_k     = {7'b0, inner_k_i} >= {outer_eff, 7'b0};
  end

  assign in_ready_o = adv;

  logic            eta_v;
  logic            kap_v;
  logic [RelW-1:0] eta_quo;
  logic [RelW-1:0] kap_quo;
  logic [16:0]     eta_side;
  logic            kap_side;

  cfr_div #(
    .NumW(32), .DenW(16), .QuoW(RelW), .StepsPerStage(RelSteps), .SideW(17)
  ) u_div_eta (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i (in_valid_i),
    .num_i      ({inner_n_i, 16'h0000}),
    .den_i      (outer_eff),
    .side_i     ({cos_mag, sat_n}),
    .out_valid_o(eta_v),
    .quo_o      (eta_quo),
    .side_o     (eta_side)
  );

  cfr_div #(
    .NumW(32), .DenW(16), .QuoW(RelW), .StepsPerStage(RelSteps), .SideW(1)
  ) u_div_kap (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i (in_valid_i),
    .num_i      ({inner_k_i, 16'h0000}),
    .den_i      (outer_eff),
    .side_i     (sat_k),
    .out_valid_o(kap_v),
    .quo_o      (kap_quo),
    .side_o     (kap_side)
  );

  // stage 1: squares of eta, kappa and cos
  logic [RelW-1:0]   eta;
  logic [RelW-1:0]   kap;
  logic [2*RelW:0]   eta_sq;
  logic [2*RelW:0]   kap_sq;
  logic [31:0]       cos_sq;
  logic              p1_v_q;
  logic [Sq2W-1:0]   p1_e2_q, p1_k2_q;
  logic [Cos2W-1:0]  p1_cos2_q;
  logic [15:0]       p1_c_q;

  always_comb begin
    eta    = (eta_side[0] || eta_quo > cfr_pkg::RelMax) ? cfr_pkg::RelMax : eta_quo;
    kap    = (kap_side || kap_quo > cfr_pkg::RelMax) ? cfr_pkg::RelMax : kap_quo;
    eta_sq = (47'(eta) * 47'(eta)) + 47'h8000;
    kap_sq = (47'(kap) * 47'(kap)) + 47'h8000;
    cos_sq = (32'(eta_side[16:1]) * 32'(eta_side[16:1])) + 32'h2000;
  end

  // stage 2: t0 and eta^2 kappa^2
  logic [Cos2W-1:0]        sin2_p2;
  logic signed [T0W-1:0]   t0_d;
  logic                    p2_v_q;
  logic signed [T0W-1:0]   p2_t0_q;
  logic [2*Sq2W-1:0]       p2_ek_q;
  logic [Cos2W-1:0]        p2_cos2_q;
  logic [15:0]             p2_c_q;

  always_comb begin
    sin2_p2 = 17'h10000 - p1_cos2_q;
    t0_d    = $signed({1'b0, p1_e2_q}) - $signed({1'b0, p1_k2_q})
            - $signed({13'b0, sin2_p2});
  end

  // stage 3: t0^2
  logic [T0W-2:0]          t0_mag;
  logic                    p3_v_q;
  logic [2*(T0W-1)-1:0]    p3_t0sq_q;
  logic [2*Sq2W-1:0]       p3_ek_q;
  logic signed [T0W-1:0]   p3_t0_q;
  logic [Cos2W-1:0]        p3_cos2_q;
  logic [15:0]             p3_c_q;

  assign t0_mag = p2_t0_q[T0W-1] ? (T0W-1)'(-p2_t0_q) : p2_t0_q[T0W-2:0];

  // stage 4: radicand of S
  logic                    p4_v_q;
  logic [SumW-1:0]         p4_sum_q;
  logic signed [T0W-1:0]   p4_t0_q;
  logic [Cos2W-1:0]        p4_cos2_q;
  logic [15:0]             p4_c_q;

  logic                    s_v;
  logic [SW-1:0]           s_root;
  logic [SideSW-1:0]       s_side;

  cfr_sqrt #(
    .RootW(SW), .StepsPerStage(RootSSteps), .SideW(SideSW)
  ) u_sqrt_s (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i (p4_v_q),
    .val_i      (p4_sum_q),
    .side_i     ({p4_t0_q, p4_cos2_q, p4_c_q}),
    .out_valid_o(s_v),
    .root_o     (s_root),
    .side_o     (s_side)
  );

  // stage 5: radicand of a
  logic signed [T0W-1:0]   s_t0;
  logic signed [31:0]      apos;
  logic                    p5_v_q;
  logic [AValW-1:0]        p5_av_q;
  logic [SW-1:0]           p5_s_q;
  logic [Cos2W-1:0]        p5_cos2_q;
  logic [15:0]             p5_c_q;

  always_comb begin
    s_t0 = s_side[SideSW-1 -: T0W];
    apos = $signed({2'b0, s_root}) + $signed({{2{s_t0[T0W-1]}}, s_t0});
  end

  logic                    a_v;
  logic [AW-1:0]           a_root;
  logic [SideAW-1:0]       a_side;

  cfr_sqrt #(
    .RootW(AW), .StepsPerStage(RootASteps), .SideW(SideAW)
  ) u_sqrt_a (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i (p5_v_q),
    .val_i      (p5_av_q),
    .side_i     ({p5_s_q, p5_cos2_q, p5_c_q}),
    .out_valid_o(a_v),
    .root_o     (a_root),
    .side_o     (a_side)
  );

  // stage 6: S + cos^2, 2 a cos, S cos^2, sin^4
  logic [SW-1:0]     a_s;
  logic [Cos2W-1:0]  a_cos2;
  logic [15:0]       a_c;
  logic [Cos2W-1:0]  sin2_p6;
  logic [AW+15:0]    ac_prod;
  logic              p6_v_q;
  logic [T1W-1:0]    p6_t1_q;
  logic [T2W-1:0]    p6_t2_q;
  logic [T3W-1:0]    p6_sc_q;
  logic [T3W-1:0]    p6_ss_q;
  logic [Cos2W-1:0]  p6_sin2_q;

  always_comb begin
    a_s     = a_side[SideAW-1 -: SW];
    a_cos2  = a_side[16 +: Cos2W];
    a_c     = a_side[15:0];
    sin2_p6 = 17'h10000 - a_cos2;
    ac_prod = ((AW+16)'(a_root) * (AW+16)'(a_c)) + (AW+16)'(14'h2000);
  end

  // stage 7: t3, t4
  logic              p7_v_q;
  logic [T1W-1:0]    p7_t1_q;
  logic [T2W-1:0]    p7_t2_q;
  logic [T3W-1:0]    p7_t3_q;
  logic [T4W-1:0]    p7_t4_q;

  // stage 8: numerators and denominators
  logic              p8_v_q;
  logic [T1W-1:0]    p8_rsn_q;
  logic [RsDenW-1:0] p8_rsd_q;
  logic [T3W-1:0]    p8_fn_q;
  logic [FDenW-1:0]  p8_fd_q;

  // stage 9: rounded dividends
  logic              p9_v_q;
  logic [RsNumW-1:0] p9_nrs_q;
  logic [RsDenW-1:0] p9_rsd_q;
  logic [FNumW-1:0]  p9_nf_q;
  logic [FDenW-1:0]  p9_fd_q;
  logic              p9_zrs_q;
  logic              p9_zf_q;

  logic              rs_v, f_v;
  logic [RatioW-1:0] rs_quo, f_quo;
  logic              rs_zero, f_zero;

  cfr_div #(
    .NumW(RsNumW), .DenW(RsDenW), .QuoW(RatioW), .StepsPerStage(RatioSteps), .SideW(1)
  ) u_div_rs (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i (p9_v_q),
    .num_i      (p9_nrs_q),
    .den_i      (p9_rsd_q),
    .side_i     (p9_zrs_q),
    .out_valid_o(rs_v),
    .quo_o      (rs_quo),
    .side_o     (rs_zero)
  );

  cfr_div #(
    .NumW(FNumW), .DenW(FDenW), .QuoW(RatioW), .StepsPerStage(RatioSteps), .SideW(1)
  ) u_div_f (
    .clk_i, .rst_ni, .adv_i(adv),
    .in_valid_i (p9_v_q),
    .num_i      (p9_nf_q),
    .den_i      (p9_fd_q),
    .side_i     (p9_zf_q),
    .out_valid_o(f_v),
    .quo_o      (f_quo),
    .side_o     (f_zero)
  );

  // stage 10: Rs and Rs * factor
  logic [RatioW-1:0] rs;
  logic [RatioW-1:0] fac;
  logic              p10_v_q;
  logic [RatioW-1:0] p10_rs_q;
  logic [31:0]       p10_rsf_q;

  always_comb begin
    rs  = (rs_zero || rs_quo > cfr_pkg::OneQ15) ? cfr_pkg::OneQ15 : rs_quo;
    fac = (f_zero || f_quo > cfr_pkg::OneQ15) ? cfr_pkg::OneQ15 : f_quo;
  end

  // output register
  logic [32:0]   rsf_rnd;
  logic [16:0]   mean_sum;
  logic [15:0]   refl_d;
  logic          out_valid_q;
  logic [15:0]   refl_q;

  always_comb begin
    rsf_rnd  = {1'b0, p10_rsf_q} + 33'h4000;
    mean_sum = {1'b0, p10_rs_q} + {1'b0, rsf_rnd[30:15]} + 17'd1;
    refl_d   = (mean_sum[16:1] > cfr_pkg::OneQ15) ? cfr_pkg::OneQ15 : mean_sum[16:1];
  end

  // hold everything only when a full last stage faces a blocked output
  assign out_load = !out_valid_q || out_ready_i;
  assign adv      = out_load || !p10_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      p7_v_q  <= 1'b0;
      p8_v_q  <= 1'b0;
      p9_v_q  <= 1'b0;
      p10_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q  <= eta_v & kap_v;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= s_v;
      p6_v_q  <= a_v;
      p7_v_q  <= p6_v_q;
      p8_v_q  <= p7_v_q;
      p9_v_q  <= p8_v_q;
      p10_v_q <= rs_v & f_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_e2_q   <= eta_sq[Sq2W+15:16];
      p1_k2_q   <= kap_sq[Sq2W+15:16];
      p1_cos2_q <= cos_sq[Cos2W+13:14];
      p1_c_q    <= eta_side[16:1];

      p2_t0_q   <= t0_d;
      p2_ek_q   <= (2*Sq2W)'(p1_e2_q) * (2*Sq2W)'(p1_k2_q);
      p2_cos2_q <= p1_cos2_q;
      p2_c_q    <= p1_c_q;

      p3_t0sq_q <= (2*(T0W-1))'(t0_mag) * (2*(T0W-1))'(t0_mag);
      p3_ek_q   <= p2_ek_q;
      p3_t0_q   <= p2_t0_q;
      p3_cos2_q <= p2_cos2_q;
      p3_c_q    <= p2_c_q;

      p4_sum_q  <= SumW'(p3_t0sq_q) + {p3_ek_q, 2'b00};
      p4_t0_q   <= p3_t0_q;
      p4_cos2_q <= p3_cos2_q;
      p4_c_q    <= p3_c_q;

      // a negative S + t0 counts as zero
      p5_av_q   <= (apos > 0) ? {apos[30:0], 15'b0} : '0;
      p5_s_q    <= s_root;
      p5_cos2_q <= s_side[16 +: Cos2W];
      p5_c_q    <= s_side[15:0];

      p6_t1_q   <= T1W'(a_s) + T1W'(a_cos2);
      p6_t2_q   <= ac_prod[T2W+13:14];
      p6_sc_q   <= T3W'(a_s) * T3W'(a_cos2);
      p6_ss_q   <= T3W'(sin2_p6) * T3W'(sin2_p6);
      p6_sin2_q <= sin2_p6;

      p7_t1_q   <= p6_t1_q;
      p7_t2_q   <= p6_t2_q;
      p7_t3_q   <= p6_sc_q + p6_ss_q;
      p7_t4_q   <= T4W'(p6_t2_q) * T4W'(p6_sin2_q);

      // a negative numerator counts as zero
      p8_rsn_q  <= (p7_t1_q > T1W'(p7_t2_q)) ? (p7_t1_q - T1W'(p7_t2_q)) : '0;
      p8_rsd_q  <= RsDenW'(p7_t1_q) + RsDenW'(p7_t2_q);
      p8_fn_q   <= (p7_t3_q > T3W'(p7_t4_q)) ? (p7_t3_q - T3W'(p7_t4_q)) : '0;
      p8_fd_q   <= FDenW'(p7_t3_q) + FDenW'(p7_t4_q);

      p9_nrs_q  <= {1'b0, p8_rsn_q, 15'b0} + RsNumW'(p8_rsd_q[RsDenW-1:1]);
      p9_rsd_q  <= p8_rsd_q;
      p9_nf_q   <= {1'b0, p8_fn_q, 15'b0} + FNumW'(p8_fd_q[FDenW-1:1]);
      p9_fd_q   <= p8_fd_q;
      p9_zrs_q  <= (p8_rsd_q == '0);
      p9_zf_q   <= (p8_fd_q == '0);

      p10_rs_q  <= rs;
      p10_rsf_q <= 32'(rs) * 32'(fac);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= p10_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      refl_q <= refl_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reflectance_o = refl_q;

endmodule
